>>> hw/rtl/rdm_pkg.sv
// Shared types and constants for the RAID array-to-disk sector map.
// Used by the top level and the testbench; depends on nothing.
package rdm_pkg;

  localparam int LEVEL_W  = 2;
  localparam int COUNT_W  = 5;
  localparam int CHUNK_W  = 21;
  localparam int DSEC_W   = 40;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = COUNT_W + DSEC_W;

  localparam logic [LEVEL_W-1:0] LVL_LINEAR = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MIRROR = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_RAID5  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_RAID6  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFIG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

  localparam logic [1:0] REG_LEVEL = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_CHUNK = 2'd2;
  localparam logic [1:0] REG_DSEC  = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] ofs;
  } ctx_a_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] ofs;
    logic [CHUNK_W-1:0]  r;
  } ctx_b_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] ofs;
    logic [CHUNK_W-1:0]  r;
    logic [SECTOR_W-1:0] quo;
    logic [SECTOR_W-1:0] rem;
    logic [COUNT_W-1:0]  modn;
  } ctx_c_t;

endpackage

>>> hw/rtl/rdm_pipe.sv
// Delay line that carries a valid bit and a context word beside a divider.
// Depends on nothing.
module rdm_pipe #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_vld,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  output logic [W-1:0] out_data
);
  logic         vld  [DEPTH];
  logic [W-1:0] data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) data[i] <= data[i-1];
    end
  end

  assign out_vld  = vld[DEPTH-1];
  assign out_data = data[DEPTH-1];
endmodule

>>> hw/rtl/rdm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the divisor travels with the dividend.
module rdm_div #(
  parameter int NW = 32,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW-1];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign t    = {rem_in, num_in[NW-1]};
    assign ge   = t >= {1'b0, den_in};
    assign diff = t - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
        num_q[i] <= {num_in[NW-2:0], ge};
      end
    end

    if (i < NW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) den_q[i] <= den_in;
      end
    end
  end

  assign quo = num_q[NW-1];
  assign rem = rem_q[NW-1];
endmodule

>>> hw/rtl/raid_array_to_disk_sector_map.sv
// Top level of the RAID array-to-disk sector map: configuration registers,
// capacity check, three divider phases and the offset table.
// Depends on rdm_pkg, rdm_div and rdm_pipe.
// An accepted request beat reaches its response beat through three entry
// stages, a 40-stage and two 32-stage divider phases, and three closing
// stages. One beat is accepted every cycle; a response stall holds
// the whole pipeline. Reset clears the valid bits, the offset table and the
// configuration registers.
module raid_array_to_disk_sector_map #(
  parameter int MAX_DISKS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [rdm_pkg::DSEC_W-1:0]    cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          opcode,
  input  logic [rdm_pkg::SECTOR_W-1:0]  array_sector,
  input  logic [rdm_pkg::SLOT_W-1:0]    slot_number,
  input  logic [rdm_pkg::SECTOR_W-1:0]  offset_value,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [rdm_pkg::SLOT_W-1:0]    disk_index,
  output logic [rdm_pkg::SECTOR_W-1:0]  disk_sector,
  output logic [rdm_pkg::STATUS_W-1:0]  status
);
  import rdm_pkg::*;

  localparam int TD  = (MAX_DISKS < 16) ? MAX_DISKS : 16;
  localparam int TIW = $clog2(TD);

  logic [LEVEL_W-1:0] raid_level;
  logic [COUNT_W-1:0] disk_count;
  logic [CHUNK_W-1:0] chunk_sectors;
  logic [DSEC_W-1:0]  disk_sectors;

  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raid_level    <= LVL_LINEAR;
      disk_count    <= COUNT_W'(1);
      chunk_sectors <= CHUNK_W'(128);
      disk_sectors  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL: raid_level    <= cfg_data[LEVEL_W-1:0];
        REG_COUNT: disk_count    <= cfg_data[COUNT_W-1:0];
        REG_CHUNK: chunk_sectors <= cfg_data[CHUNK_W-1:0];
        REG_DSEC:  disk_sectors  <= cfg_data;
      endcase
    end
  end

  // Entry stages.
  logic                vld0, vld1, vld2;
  logic                op0, op1;
  logic [SECTOR_W-1:0] sec0, sec1, sec2;
  logic [SLOT_W-1:0]   slot0, slot1, slot2;
  logic [SECTOR_W-1:0] ofs0, ofs1, ofs2;
  logic [CAP_W-1:0]    cap1;
  logic                inv1;
  logic [STATUS_W-1:0] st2;
  logic [COUNT_W-1:0]  fac;
  logic [CAP_W-1:0]    cap_next;
  logic                inv_next;

  always_comb begin
    unique case (raid_level)
      LVL_LINEAR: fac = disk_count;
      LVL_MIRROR: fac = COUNT_W'(1);
      LVL_RAID5:  fac = disk_count - COUNT_W'(1);
      LVL_RAID6:  fac = disk_count - COUNT_W'(2);
    endcase
  end

  assign cap_next = {{DSEC_W{1'b0}}, fac} * {{COUNT_W{1'b0}}, disk_sectors};
  assign inv_next = (disk_count == '0) || (int'(disk_count) > MAX_DISKS) ||
                    (chunk_sectors == '0) ||
                    (raid_level == LVL_RAID5 && disk_count < COUNT_W'(2)) ||
                    (raid_level == LVL_RAID6 && disk_count < COUNT_W'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld0 <= req_valid;
      vld1 <= vld0;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0   <= opcode;
      sec0  <= array_sector;
      slot0 <= slot_number;
      ofs0  <= offset_value;
      op1   <= op0;
      sec1  <= sec0;
      slot1 <= slot0;
      ofs1  <= ofs0;
      cap1  <= cap_next;
      inv1  <= inv_next;
      sec2  <= sec1;
      slot2 <= slot1;
      ofs2  <= ofs1;
      if (op1) begin
        st2 <= ST_LOADED;
      end else if (inv1) begin
        st2 <= ST_CONFIG;
      end else if (CAP_W'(sec1) >= cap1) begin
        st2 <= ST_RANGE;
      end else begin
        st2 <= ST_MAPPED;
      end
    end
  end

  // Phase A: chunk number of the sector and whole chunks per disk.
  localparam int AW = DSEC_W;
  logic [AW-1:0]      qa, qd;
  logic [CHUNK_W-1:0] ra, rd_unused;
  ctx_a_t             ctx_a_in, ctx_a;
  logic               vld_a;

  assign ctx_a_in = '{st: st2, slot: slot2, ofs: ofs2};

  rdm_div #(.NW(AW), .DW(CHUNK_W)) u_div_sec (
    .clk(clk), .en(en), .num(AW'(sec2)), .den(chunk_sectors), .quo(qa), .rem(ra)
  );
  rdm_div #(.NW(AW), .DW(CHUNK_W)) u_div_dsk (
    .clk(clk), .en(en), .num(disk_sectors), .den(chunk_sectors), .quo(qd),
    .rem(rd_unused)
  );
  rdm_pipe #(.W($bits(ctx_a_t)), .DEPTH(AW)) u_pipe_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld2), .in_data(ctx_a_in),
    .out_vld(vld_a), .out_data(ctx_a)
  );

  // Phase B: stripe (or linear disk) and chunk modulo the disk count.
  logic [DSEC_W-1:0]   m;
  logic [STATUS_W-1:0] st_b;
  logic [SECTOR_W-1:0] qb, qn_unused;
  logic [DSEC_W-1:0]   rb;
  logic [COUNT_W-1:0]  rn;
  ctx_b_t              ctx_b_in, ctx_b;
  logic                vld_b;

  always_comb begin
    unique case (raid_level)
      LVL_LINEAR: m = qd;
      LVL_MIRROR: m = DSEC_W'(1);
      LVL_RAID5:  m = DSEC_W'(disk_count - COUNT_W'(1));
      LVL_RAID6:  m = DSEC_W'(disk_count - COUNT_W'(2));
    endcase
  end

  assign st_b = (ctx_a.st == ST_MAPPED && raid_level == LVL_LINEAR && qd == '0)
                ? ST_RANGE : ctx_a.st;
  assign ctx_b_in = '{st: st_b, slot: ctx_a.slot, ofs: ctx_a.ofs, r: ra};

  rdm_div #(.NW(SECTOR_W), .DW(DSEC_W)) u_div_stripe (
    .clk(clk), .en(en), .num(qa[SECTOR_W-1:0]), .den(m), .quo(qb), .rem(rb)
  );
  rdm_div #(.NW(SECTOR_W), .DW(COUNT_W)) u_div_modn (
    .clk(clk), .en(en), .num(qa[SECTOR_W-1:0]), .den(disk_count), .quo(qn_unused),
    .rem(rn)
  );
  rdm_pipe #(.W($bits(ctx_b_t)), .DEPTH(SECTOR_W)) u_pipe_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld_a), .in_data(ctx_b_in),
    .out_vld(vld_b), .out_data(ctx_b)
  );

  // Phase C: stripe modulo the disk count for the rotating parity.
  logic [SECTOR_W-1:0] qs_unused;
  logic [COUNT_W-1:0]  rs;
  ctx_c_t              ctx_c_in, ctx_c;
  logic                vld_c;

  assign ctx_c_in = '{st: ctx_b.st, slot: ctx_b.slot, ofs: ctx_b.ofs, r: ctx_b.r,
                      quo: qb, rem: rb[SECTOR_W-1:0], modn: rn};

  rdm_div #(.NW(SECTOR_W), .DW(COUNT_W)) u_div_rot (
    .clk(clk), .en(en), .num(qb), .den(disk_count), .quo(qs_unused), .rem(rs)
  );
  rdm_pipe #(.W($bits(ctx_c_t)), .DEPTH(SECTOR_W)) u_pipe_c (
    .clk(clk), .rst(rst), .en(en), .in_vld(vld_b), .in_data(ctx_c_in),
    .out_vld(vld_c), .out_data(ctx_c)
  );

  // Closing stages: member sector, disk number, offset add.
  logic [SECTOR_W-1:0]         src;
  logic [SECTOR_W+CHUNK_W-1:0] prod_next;
  logic [COUNT_W-1:0]          pd;
  logic [COUNT_W:0]            t6, d6;
  logic [SLOT_W-1:0]           disk_next;
  logic [STATUS_W-1:0]         st_d_next;

  assign src       = (raid_level == LVL_LINEAR) ? ctx_c.rem : ctx_c.quo;
  assign prod_next = {{CHUNK_W{1'b0}}, src} * {{SECTOR_W{1'b0}}, chunk_sectors};
  assign pd        = disk_count - COUNT_W'(1) - rs;
  assign t6        = {1'b0, pd} + (COUNT_W+1)'(2) + {1'b0, ctx_c.rem[COUNT_W-1:0]};
  assign d6        = (t6 >= {1'b0, disk_count}) ? t6 - {1'b0, disk_count} : t6;

  always_comb begin
    unique case (raid_level)
      LVL_LINEAR: disk_next = ctx_c.quo[SLOT_W-1:0];
      LVL_MIRROR: disk_next = '0;
      LVL_RAID5:  disk_next = ctx_c.modn[SLOT_W-1:0];
      LVL_RAID6:  disk_next = d6[SLOT_W-1:0];
    endcase
  end

  assign st_d_next = (ctx_c.st == ST_MAPPED && raid_level == LVL_LINEAR &&
                      ctx_c.quo >= SECTOR_W'(disk_count)) ? ST_RANGE : ctx_c.st;

  logic                vld_d, vld_e;
  logic [STATUS_W-1:0] st_d, st_e;
  logic [SLOT_W-1:0]   slot_d, slot_e, disk_d, disk_e;
  logic [SECTOR_W-1:0] ofs_d, ofs_e, prod_d, sum_e;
  logic [CHUNK_W-1:0]  r_d;
  logic [SECTOR_W-1:0] offset_table [TD];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
      vld_e <= 1'b0;
    end else if (en) begin
      vld_d <= vld_c;
      vld_e <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_d   <= st_d_next;
      slot_d <= ctx_c.slot;
      ofs_d  <= ctx_c.ofs;
      r_d    <= ctx_c.r;
      disk_d <= disk_next;
      prod_d <= prod_next[SECTOR_W-1:0];
      st_e   <= st_d;
      slot_e <= slot_d;
      ofs_e  <= ofs_d;
      disk_e <= disk_d;
      sum_e  <= prod_d + SECTOR_W'(r_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      for (int i = 0; i < TD; i++) offset_table[i] <= '0;
    end else if (en) begin
      rsp_valid <= vld_e;
      if (vld_e && st_e == ST_LOADED && int'(slot_e) < MAX_DISKS) begin
        offset_table[slot_e[TIW-1:0]] <= ofs_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= st_e;
      if (st_e == ST_MAPPED) begin
        disk_index  <= disk_e;
        disk_sector <= sum_e + offset_table[disk_e[TIW-1:0]];
      end else begin
        disk_index  <= '0;
        disk_sector <= '0;
      end
    end
  end

  a_disk_in_array: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_MAPPED |-> COUNT_W'(disk_index) < disk_count)
    else $error("mapped disk index not below disk count");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_MAPPED |-> disk_index == '0 && disk_sector == '0)
    else $error("non-mapped response carries nonzero fields");

  a_mirror_disk0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_MAPPED && raid_level == LVL_MIRROR |-> disk_index == '0)
    else $error("mirror response not on disk zero");
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for raid_array_to_disk_sector_map: directed and random
// map and offset-load requests under several idling phases. Depends on rdm_pkg.
`timescale 1ns / 100ps

module tb_top;
  import rdm_pkg::*;

  localparam int MAXD = 16;
  localparam longint LIMIT = 1500000;

  typedef struct packed {
    logic [SLOT_W-1:0]   disk;
    logic [SECTOR_W-1:0] sec;
    logic [STATUS_W-1:0] st;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = REG_LEVEL;
  logic [DSEC_W-1:0] cfg_data = '0;
  logic req_valid = 0;
  logic opcode = 0;
  logic [SECTOR_W-1:0] array_sector = '0;
  logic [SLOT_W-1:0] slot_number = '0;
  logic [SECTOR_W-1:0] offset_value = '0;
  logic rsp_ready = 0;
  logic cfg_ready, req_ready, rsp_valid;
  logic [SLOT_W-1:0] disk_index;
  logic [SECTOR_W-1:0] disk_sector;
  logic [STATUS_W-1:0] status;

  logic [LEVEL_W-1:0] m_level = LVL_LINEAR;
  logic [COUNT_W-1:0] m_count = 1;
  logic [CHUNK_W-1:0] m_chunk = 128;
  logic [DSEC_W-1:0]  m_dsec = 0;
  logic [SECTOR_W-1:0] m_offs [MAXD];

  answer_t pending_answers[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  raid_array_to_disk_sector_map dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic answer_t map_sector(logic [SECTOR_W-1:0] sector);
    answer_t a;
    longint unsigned n, c, d, s, cap, per, chunk, stripe, k, pd, dk, sc;
    a = '0;
    n = 64'(m_count); c = 64'(m_chunk); d = 64'(m_dsec); s = 64'(sector);
    if (n == 0 || n > MAXD || c == 0 || (m_level == LVL_RAID5 && n < 2) ||
        (m_level == LVL_RAID6 && n < 3)) begin
      a.st = ST_CONFIG;
      return a;
    end
    case (m_level)
      LVL_LINEAR: cap = n * d;
      LVL_MIRROR: cap = d;
      LVL_RAID5:  cap = (n - 1) * d;
      default:    cap = (n - 2) * d;
    endcase
    if (s >= cap) begin
      a.st = ST_RANGE;
      return a;
    end
    if (m_level == LVL_LINEAR) begin
      per = d / c * c;
      if (per == 0 || s / per >= n) begin
        a.st = ST_RANGE;
        return a;
      end
      dk = s / per; sc = s % per;
    end else if (m_level == LVL_MIRROR) begin
      dk = 0; sc = s;
    end else if (m_level == LVL_RAID5) begin
      chunk = s / c; stripe = chunk / (n - 1);
      dk = chunk % n; sc = stripe * c + s % c;
    end else begin
      chunk = s / c; stripe = chunk / (n - 2); k = chunk % (n - 2);
      pd = n - 1 - stripe % n;
      dk = (pd + 2 + k) % n; sc = stripe * c + s % c;
    end
    a.disk = dk[SLOT_W-1:0];
    a.sec = sc[SECTOR_W-1:0] + m_offs[dk[SLOT_W-1:0]];
    a.st = ST_MAPPED;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && rsp_valid && rsp_ready) begin
      got = '{disk: disk_index, sec: disk_sector, st: status};
      if (pending_answers.size() == 0) begin
        $error("unexpected response beat");
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.disk !== want.disk) begin
          $error("disk_index exp %0d got %0d", want.disk, got.disk); errors++;
        end
        if (got.sec !== want.sec) begin
          $error("disk_sector exp %0d got %0d", want.sec, got.sec); errors++;
        end
        if (got.st !== want.st) begin
          $error("status exp %0d got %0d", want.st, got.st); errors++;
        end
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] sec, logic [3:0] slot, logic [31:0] ofs);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1; opcode <= op; array_sector <= sec;
    slot_number <= slot; offset_value <= ofs;
    if (op) begin
      a = '0; a.st = ST_LOADED;
      m_offs[slot] = ofs;
    end else a = map_sector(sec);
    pending_answers = {pending_answers, a};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DSEC_W-1:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEVEL: m_level = val[LEVEL_W-1:0];
      REG_COUNT: m_count = val[COUNT_W-1:0];
      REG_CHUNK: m_chunk = val[CHUNK_W-1:0];
      default:   m_dsec = val;
    endcase
  endtask

  task automatic configure(logic [1:0] lvl, logic [4:0] n, logic [20:0] c, logic [39:0] d);
    drain();
    write_reg(REG_LEVEL, DSEC_W'(lvl));
    write_reg(REG_COUNT, DSEC_W'(n));
    write_reg(REG_CHUNK, DSEC_W'(c));
    write_reg(REG_DSEC, d);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_sector(logic [39:0] span);
    longint unsigned lim;
    lim = 64'(span);
    if ($urandom_range(9) == 0 || lim == 0) return $urandom;
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    if ($urandom_range(5) == 0) return 32'(lim - 64'($urandom_range(2)));
    return 32'({$urandom} % (lim + 1));
  endfunction

  task automatic test_directed();
    send_request(0, 0, 0, 0);
    send_request(0, 32'hFFFF_FFFF, 0, 0);
    send_request(1, 0, 4'hF, 32'hFFFF_FFFF);
    send_request(1, 0, 0, 32'hFFFF_FFF0);
    send_request(1, 0, 5, 32'h5555_5555);
    configure(LVL_LINEAR, 4, 128, 1000);
    send_request(0, 0, 0, 0);
    send_request(0, 895, 0, 0);
    send_request(0, 896, 0, 0);
    send_request(0, 3583, 0, 0);
    send_request(0, 3584, 0, 0);
    send_request(0, 3999, 0, 0);
    send_request(0, 4000, 0, 0);
    configure(LVL_LINEAR, 2, 128, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_MIRROR, 0, 8, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_MIRROR, 17, 8, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_MIRROR, 2, 0, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_RAID5, 1, 8, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_RAID6, 2, 8, 100);
    send_request(0, 5, 0, 0);
    configure(LVL_RAID6, 16, 21'h100000, 40'hFF_FFFF_FFFF);
    send_request(0, 32'hFFFF_FFFF, 0, 0);
    configure(LVL_RAID5, 16, 1, 40'hFF_FFFF_FFFF);
    send_request(0, 32'hFFFF_FFFF, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [1:0] lvl;
    logic [4:0] n;
    logic [20:0] c;
    logic [39:0] d;
    logic [39:0] span;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        lvl = 2'($urandom_range(3));
        n = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
        c = ($urandom_range(15) == 0) ? 21'($urandom_range(0, 1)) :
            ($urandom_range(7) == 0 ? 21'h100000 : (21'd1 << $urandom_range(10)));
        d = ($urandom_range(9) == 0) ? 40'({$urandom, $urandom}) :
            40'($urandom_range(100000));
        configure(lvl, n, c, d);
        span = (lvl == LVL_MIRROR) ? d : d * {35'd0, n};
      end
      if ($urandom_range(9) == 0)
        send_request(1, $urandom, 4'($urandom), $urandom);
      else
        send_request(0, rand_sector(span), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < MAXD; i++) m_offs[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(600);
    send_idle_pct = 88; recv_stall_pct = 0;  test_random(400);
    send_idle_pct = 0;  recv_stall_pct = 88; test_random(400);
    send_idle_pct = 8;  recv_stall_pct = 8;  test_random(450);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
